/* rtl/core/ebft_pkg.sv */
// Shared types and constants for the elevation band frustum test unit.
package ebft_pkg;

    localparam int unsigned LEN_W   = 32;
    localparam int unsigned RAD_W   = 31;
    localparam int unsigned TRIG_W  = 16;
    localparam int unsigned ROOT_W  = 32;
    localparam int unsigned SQ_W    = 64;
    localparam int unsigned PROD_W  = 51;
    localparam int unsigned ADDR_W  = 5;

    localparam logic [2:0] REG_NEAR     = 3'd0;
    localparam logic [2:0] REG_FAR      = 3'd1;
    localparam logic [2:0] REG_SIN_LOW  = 3'd2;
    localparam logic [2:0] REG_COS_LOW  = 3'd3;
    localparam logic [2:0] REG_SIN_HIGH = 3'd4;
    localparam logic [2:0] REG_COS_HIGH = 3'd5;

    // One decoded item as the front hands it to the back.
    typedef struct packed {
        logic              no_far;
        logic [LEN_W-1:0]  abs_x;
        logic [LEN_W-1:0]  abs_y;
        logic [LEN_W-1:0]  abs_z;
        logic signed [LEN_W-1:0] z;
        logic [RAD_W-1:0]  radius;
    } item_t;

    typedef struct packed {
        logic [RAD_W-1:0]         near_range;
        logic [RAD_W-1:0]         far_range;
        logic signed [TRIG_W-1:0] sin_low;
        logic signed [TRIG_W-1:0] cos_low;
        logic signed [TRIG_W-1:0] sin_high;
        logic signed [TRIG_W-1:0] cos_high;
    } cfg_t;

endpackage

/* rtl/core/elevation_band_frustum_test_unit.sv */
// Top level of the elevation band frustum test unit.
//
// Usage: drive opcode, pos_x, pos_y, pos_z and sphere_radius with start high;
// the word is taken at a rising edge where start is high and busy is low.
// Each accepted word yields one inside_res, shown for exactly one cycle with
// done high; the receiver cannot hold results off and need not.
// A word passes the front register, the queue, stages 1 to 3, the square
// root stages and the product stage before done rises. Throughput is one
// word per cycle while busy is low; most of the delay lies in the square
// root pipeline, which resolves one root bit per stage over 32 stages.
// busy rises only if the queue between front and back fills, which does not
// happen in normal use since the back end never stalls.
// The APB port at byte addresses 4*i holds near_range, far_range,
// sin_low_elev, cos_low_elev, sin_high_elev and cos_high_elev; write them
// only while no word is in flight. Writes with paddr[4:2] of 6 or 7 are ignored.
// Reset clears the pipeline and loads the register defaults: a near range of
// zero, the largest far range and a full band from straight down to straight
// up.
module elevation_band_frustum_test_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ebft_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   opcode,
    input  logic signed [31:0]           pos_x,
    input  logic signed [31:0]           pos_y,
    input  logic signed [31:0]           pos_z,
    input  logic [30:0]                  sphere_radius,
    output logic                         done,
    output logic                         inside_res
);

    ebft_pkg::cfg_t  cfg_reg;
    ebft_pkg::item_t front_item;
    ebft_pkg::item_t queue_head;
    logic            front_valid;
    logic            queue_not_empty;
    logic            queue_full;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign busy    = queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_range <= '0;
            cfg_reg.far_range  <= '1;
            cfg_reg.sin_low    <= 16'sh8000;
            cfg_reg.cos_low    <= '0;
            cfg_reg.sin_high   <= 16'sh7FFF;
            cfg_reg.cos_high   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                ebft_pkg::REG_NEAR:     cfg_reg.near_range <= pwdata[30:0];
                ebft_pkg::REG_FAR:      cfg_reg.far_range  <= pwdata[30:0];
                ebft_pkg::REG_SIN_LOW:  cfg_reg.sin_low    <= pwdata[15:0];
                ebft_pkg::REG_COS_LOW:  cfg_reg.cos_low    <= pwdata[15:0];
                ebft_pkg::REG_SIN_HIGH: cfg_reg.sin_high   <= pwdata[15:0];
                ebft_pkg::REG_COS_HIGH: cfg_reg.cos_high   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            ebft_pkg::REG_NEAR:     prdata = {1'b0, cfg_reg.near_range};
            ebft_pkg::REG_FAR:      prdata = {1'b0, cfg_reg.far_range};
            ebft_pkg::REG_SIN_LOW:  prdata = 32'(cfg_reg.sin_low);
            ebft_pkg::REG_COS_LOW:  prdata = 32'(cfg_reg.cos_low);
            ebft_pkg::REG_SIN_HIGH: prdata = 32'(cfg_reg.sin_high);
            ebft_pkg::REG_COS_HIGH: prdata = 32'(cfg_reg.cos_high);
            default:                prdata = '0;
        endcase
    end

    ebft_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (start && !busy),
        .opcode        (opcode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .sphere_radius (sphere_radius),
        .item_valid    (front_valid),
        .item          (front_item)
    );

    ebft_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_item (front_item),
        .pop       (1'b1),
        .not_empty (queue_not_empty),
        .full      (queue_full),
        .head      (queue_head)
    );

    ebft_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (queue_not_empty),
        .in_item    (queue_head),
        .cfg        (cfg_reg),
        .done       (done),
        .inside_res (inside_res)
    );

endmodule

/* rtl/core/ebft_front.sv */
// Front end: accepts a word, masks the radius and takes absolute values.
module ebft_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [1:0]                    opcode,
    input  logic signed [31:0]            pos_x,
    input  logic signed [31:0]            pos_y,
    input  logic signed [31:0]            pos_z,
    input  logic [ebft_pkg::RAD_W-1:0]    sphere_radius,
    output logic                          item_valid,
    output ebft_pkg::item_t               item
);

    logic            valid_reg;
    ebft_pkg::item_t item_reg;
    ebft_pkg::item_t item_next;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        abs32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    always_comb
    begin
        item_next.no_far = opcode[0];
        item_next.abs_x  = abs32(pos_x);
        item_next.abs_y  = abs32(pos_y);
        item_next.abs_z  = abs32(pos_z);
        item_next.z      = pos_z;
        item_next.radius = opcode[1] ? sphere_radius : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/core/ebft_queue.sv */
// Two-entry word queue between the front and the back.
module ebft_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ebft_pkg::item_t push_item,
    input  logic            pop,
    output logic            not_empty,
    output logic            full,
    output ebft_pkg::item_t head
);

    ebft_pkg::item_t store_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            do_pop;

    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign do_pop    = pop && not_empty;
    assign head      = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/core/ebft_back.sv */
// Back end: squares, range tests, pipelined square root and band tests.
module ebft_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ebft_pkg::item_t in_item,
    input  ebft_pkg::cfg_t  cfg,
    output logic            done,
    output logic            inside_res
);

    localparam int unsigned NB = ebft_pkg::ROOT_W;
    localparam int unsigned TW = ebft_pkg::SQ_W + 2;

    // Stage 1: squares and range limits.
    logic                       s1_valid_reg;
    logic [63:0]                s1_sqx_reg, s1_sqy_reg, s1_sqz_reg;
    logic [31:0]                s1_farlim_reg, s1_nearlim_reg;
    logic                       s1_near_act_reg, s1_no_far_reg;
    logic signed [31:0]         s1_z_reg;
    logic [ebft_pkg::RAD_W-1:0] s1_r_reg;

    // Stage 2: horizontal sum and squared limits.
    logic                       s2_valid_reg;
    logic [63:0]                s2_h2_reg, s2_sqz_reg, s2_farsq_reg, s2_nearsq_reg;
    logic                       s2_near_act_reg, s2_no_far_reg;
    logic signed [31:0]         s2_z_reg;
    logic [ebft_pkg::RAD_W-1:0] s2_r_reg;

    // Stage 3: full norm.
    logic                       s3_valid_reg;
    logic [63:0]                s3_h2_reg, s3_n2_reg, s3_farsq_reg, s3_nearsq_reg;
    logic                       s3_near_act_reg, s3_no_far_reg;
    logic signed [31:0]         s3_z_reg;
    logic [ebft_pkg::RAD_W-1:0] s3_r_reg;

    // Square root pipeline, one result bit per stage.
    logic                       sq_valid_reg [NB+1];
    logic [63:0]                sq_rem_reg   [NB+1];
    logic [NB-1:0]              sq_root_reg  [NB+1];
    logic                       sq_rej_reg   [NB+1];
    logic                       sq_nz_reg    [NB+1];
    logic signed [31:0]         sq_z_reg     [NB+1];
    logic [ebft_pkg::RAD_W-1:0] sq_r_reg     [NB+1];

    logic [TW-1:0]              trial      [NB];
    logic                       take_bit   [NB];

    // Product stage.
    logic                         p_valid_reg, p_rej_reg, p_nz_reg;
    logic signed [ebft_pkg::PROD_W-1:0] p_los_reg, p_loc_reg, p_his_reg, p_hic_reg;
    logic signed [ebft_pkg::PROD_W-1:0] p_rs_reg;

    logic done_reg, inside_reg;
    logic range_rej;
    logic lo_rej, hi_rej;
    logic signed [32:0] h_ext;

    assign range_rej = (!s3_no_far_reg && (s3_n2_reg > s3_farsq_reg))
                    || (s3_near_act_reg && (s3_n2_reg < s3_nearsq_reg));

    always_comb
    begin
        for (int k = 0; k < NB; k++)
        begin
            // Growth of the square when bit (NB-1-k) is added to the root.
            trial[k] = (TW'(sq_root_reg[k]) << (NB - k))
                     + (TW'(1) << (2 * (NB - 1 - k)));
            take_bit[k] = (TW'(sq_rem_reg[k]) >= trial[k]);
        end
    end

    assign h_ext = $signed({1'b0, sq_root_reg[NB]});

    assign lo_rej = (p_loc_reg < p_los_reg) && ((p_los_reg - p_loc_reg) > p_rs_reg);
    assign hi_rej = (p_hic_reg > p_his_reg) && ((p_hic_reg - p_his_reg) > p_rs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int k = 0; k <= NB; k++)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            p_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= in_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            sq_valid_reg[0] <= s3_valid_reg;
            for (int k = 0; k < NB; k++)
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
            p_valid_reg <= sq_valid_reg[NB];
            done_reg    <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sqx_reg      <= 64'(in_item.abs_x) * 64'(in_item.abs_x);
        s1_sqy_reg      <= 64'(in_item.abs_y) * 64'(in_item.abs_y);
        s1_sqz_reg      <= 64'(in_item.abs_z) * 64'(in_item.abs_z);
        s1_farlim_reg   <= 32'(cfg.far_range) + 32'(in_item.radius);
        s1_nearlim_reg  <= 32'(cfg.near_range) - 32'(in_item.radius);
        s1_near_act_reg <= (in_item.radius < cfg.near_range);
        s1_no_far_reg   <= in_item.no_far;
        s1_z_reg        <= in_item.z;
        s1_r_reg        <= in_item.radius;

        s2_h2_reg       <= s1_sqx_reg + s1_sqy_reg;
        s2_sqz_reg      <= s1_sqz_reg;
        s2_farsq_reg    <= 64'(s1_farlim_reg) * 64'(s1_farlim_reg);
        s2_nearsq_reg   <= 64'(s1_nearlim_reg) * 64'(s1_nearlim_reg);
        s2_near_act_reg <= s1_near_act_reg;
        s2_no_far_reg   <= s1_no_far_reg;
        s2_z_reg        <= s1_z_reg;
        s2_r_reg        <= s1_r_reg;

        s3_h2_reg       <= s2_h2_reg;
        s3_n2_reg       <= s2_h2_reg + s2_sqz_reg;
        s3_farsq_reg    <= s2_farsq_reg;
        s3_nearsq_reg   <= s2_nearsq_reg;
        s3_near_act_reg <= s2_near_act_reg;
        s3_no_far_reg   <= s2_no_far_reg;
        s3_z_reg        <= s2_z_reg;
        s3_r_reg        <= s2_r_reg;

        sq_rem_reg[0]  <= s3_h2_reg;
        sq_root_reg[0] <= '0;
        sq_rej_reg[0]  <= range_rej;
        sq_nz_reg[0]   <= (s3_n2_reg != 64'd0);
        sq_z_reg[0]    <= s3_z_reg;
        sq_r_reg[0]    <= s3_r_reg;

        for (int k = 0; k < NB; k++)
        begin
            if (take_bit[k])
            begin
                sq_rem_reg[k+1]  <= 64'(TW'(sq_rem_reg[k]) - trial[k]);
                sq_root_reg[k+1] <= sq_root_reg[k] | (NB'(1) << (NB - 1 - k));
            end
            else
            begin
                sq_rem_reg[k+1]  <= sq_rem_reg[k];
                sq_root_reg[k+1] <= sq_root_reg[k];
            end
            sq_rej_reg[k+1] <= sq_rej_reg[k];
            sq_nz_reg[k+1]  <= sq_nz_reg[k];
            sq_z_reg[k+1]   <= sq_z_reg[k];
            sq_r_reg[k+1]   <= sq_r_reg[k];
        end

        p_rej_reg <= sq_rej_reg[NB];
        p_nz_reg  <= sq_nz_reg[NB];
        p_los_reg <= ebft_pkg::PROD_W'(cfg.sin_low * h_ext);
        p_his_reg <= ebft_pkg::PROD_W'(cfg.sin_high * h_ext);
        p_loc_reg <= ebft_pkg::PROD_W'(cfg.cos_low * sq_z_reg[NB]);
        p_hic_reg <= ebft_pkg::PROD_W'(cfg.cos_high * sq_z_reg[NB]);
        p_rs_reg  <= $signed({5'd0, sq_r_reg[NB], 15'd0});

        inside_reg <= !p_rej_reg && !(p_nz_reg && (lo_rej || hi_rej));
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;

endmodule
